>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/jerc_pkg.sv
// ----------------------------------------------------------------------------
// jerc_pkg
// Types, constants and the gear/flap table of the stick/pedal to RC mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package jerc_pkg;

    localparam int CHANNEL_COUNT = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [11:0] CENTER   = 12'd992;
    localparam logic [9:0]  SPAN     = 10'd819;
    localparam logic [15:0] FULL     = 16'd32767;
    localparam logic [11:0] VAL_MIN  = 12'd172;
    localparam logic [11:0] VAL_MAX  = 12'd1811;
    localparam logic [10:0] DZ_LO    = 11'(992 - 50);
    localparam logic [10:0] DZ_HI    = 11'(992 + 50);

    localparam logic [7:0] AXIS_PEDAL_RUDDER = 8'd2;
    localparam logic [7:0] AXIS_STICK_RUDDER = 8'd5;
    localparam logic [7:0] AXIS_FIRST_SHIFT  = 8'd3;
    localparam logic [7:0] AXIS_SHIFT_END    = 8'd8;
    localparam logic [7:0] AXIS_END          = 8'(CHANNEL_COUNT);
    localparam logic [7:0] BTN_TOGGLE        = 8'd6;
    localparam logic [7:0] BTN_FLAP_POS0     = 8'd13;
    localparam logic [7:0] BTN_FLAP_POS1     = 8'd14;
    localparam logic [7:0] BTN_FLAP_POS2     = 8'd15;
    localparam logic [7:0] BTN_GEAR_UP       = 8'd16;
    localparam logic [7:0] BTN_GEAR_DOWN     = 8'd17;

    localparam logic [3:0] CH_INVERTED  = 4'd2;
    localparam logic [3:0] CH_RUDDER    = 4'd3;
    localparam logic [3:0] CH_GEAR_FLAP = 4'd4;
    localparam logic [3:0] CH_AXIS_FIVE = 4'd7;
    localparam logic [3:0] CH_SHIFT     = 4'd2;

    localparam logic [1:0] FLAP_POS0 = 2'd0;
    localparam logic [1:0] FLAP_POS1 = 2'd1;
    localparam logic [1:0] FLAP_POS2 = 2'd2;

    typedef struct packed {
        logic               from_pedals;
        logic               is_button;
        logic [7:0]         control_number;
        logic signed [15:0] event_value;
    } event_item_t;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] channel_value;
        logic        ready_res;
        logic        last_write;
    } channel_write_t;

    // classified event, one mapped value per event
    typedef struct packed {
        logic [3:0]         ch_a;
        logic [3:0]         ch_b;
        logic               two;
        logic               use_map;
        logic signed [16:0] operand;
        logic [10:0]        fixed_value;
        logic [3:0]         mask;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  ch_a;
        logic [3:0]  ch_b;
        logic        two;
        logic [10:0] value;
        logic        ready;
    } entry_t;

    function automatic logic [10:0] gear_flap_value(input logic gear, input logic [1:0] flap);
        logic [10:0] val;
        val = 11'd172;
        case ({gear, flap})
            3'b000:  val = 11'd172;
            3'b001:  val = 11'd499;
            3'b010:  val = 11'd826;
            3'b100:  val = 11'd1153;
            3'b101:  val = 11'd1480;
            3'b110:  val = 11'd1811;
            default: val = 11'd172;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

>>> rtl/jerc_front.sv
// ----------------------------------------------------------------------------
// jerc_front
// Accepts events, keeps mode state and classifies each event into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module jerc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire jerc_pkg::event_item_t            event_item,
    input  wire logic                             s2_valid,
    input  wire logic [jerc_pkg::QUEUE_CW-1:0]    q_count,
    output logic                                  s1_valid,
    output jerc_pkg::cmd_t                        s1_cmd
);

    logic                accept;
    logic [2:0]          in_flight;

    logic                gear_reg, gear_next;
    logic [1:0]          flap_reg, flap_next;
    logic                rfs_reg, rfs_next;
    logic signed [15:0]  stored_reg, stored_next;
    logic                s1_valid_reg;
    jerc_pkg::cmd_t      s1_cmd_reg, cmd_next;
    logic                has_write;

    assign in_flight = 3'(q_count) + {2'd0, s1_valid_reg} + {2'd0, s2_valid};
    assign full      = in_flight >= 3'(jerc_pkg::QUEUE_DEPTH);
    assign accept    = push && !full;

    always_comb
    begin
        logic [7:0]         num;
        logic signed [16:0] op_v;
        logic               pressed;
        logic [3:0]         ch;
        num         = event_item.control_number;
        op_v        = {event_item.event_value[15], event_item.event_value};
        pressed     = event_item.event_value == 16'sd1;
        ch          = num[3:0];
        gear_next   = gear_reg;
        flap_next   = flap_reg;
        rfs_next    = rfs_reg;
        stored_next = stored_reg;
        has_write   = 1'b0;
        cmd_next    = '0;
        cmd_next.operand = op_v;
        if (event_item.from_pedals)
        begin
            if (!event_item.is_button && num == jerc_pkg::AXIS_PEDAL_RUDDER && !rfs_reg)
            begin
                has_write        = 1'b1;
                cmd_next.ch_a    = jerc_pkg::CH_RUDDER;
                cmd_next.use_map = 1'b1;
                cmd_next.mask    = 4'b1000;
            end
        end
        else if (!event_item.is_button)
        begin
            if (num < jerc_pkg::AXIS_SHIFT_END)
            begin
                if (num >= jerc_pkg::AXIS_FIRST_SHIFT)
                    ch = num[3:0] + jerc_pkg::CH_SHIFT;
                has_write        = 1'b1;
                cmd_next.ch_a    = ch;
                cmd_next.use_map = 1'b1;
                if (ch == jerc_pkg::CH_INVERTED)
                    cmd_next.operand = -op_v;
                if (ch < jerc_pkg::CH_RUDDER)
                    cmd_next.mask = 4'(1) << ch;
                if (num == jerc_pkg::AXIS_STICK_RUDDER)
                begin
                    stored_next = event_item.event_value;
                    if (rfs_reg)
                    begin
                        cmd_next.two  = 1'b1;
                        cmd_next.ch_b = jerc_pkg::CH_RUDDER;
                        cmd_next.mask = 4'b1000;
                    end
                end
            end
            else if (num < jerc_pkg::AXIS_END)
            begin
                has_write        = 1'b1;
                cmd_next.ch_a    = ch;
                cmd_next.use_map = 1'b1;
            end
        end
        else if (num == jerc_pkg::BTN_TOGGLE && !pressed)
        begin
            rfs_next = !rfs_reg;
            if (!rfs_reg)
            begin
                has_write        = 1'b1;
                cmd_next.ch_a    = jerc_pkg::CH_RUDDER;
                cmd_next.use_map = 1'b1;
                cmd_next.operand = {stored_reg[15], stored_reg};
            end
        end
        else if (pressed)
        begin
            has_write = 1'b1;
            case (num)
                jerc_pkg::BTN_FLAP_POS0: flap_next = jerc_pkg::FLAP_POS0;
                jerc_pkg::BTN_FLAP_POS1: flap_next = jerc_pkg::FLAP_POS1;
                jerc_pkg::BTN_FLAP_POS2: flap_next = jerc_pkg::FLAP_POS2;
                jerc_pkg::BTN_GEAR_UP:   gear_next = 1'b1;
                jerc_pkg::BTN_GEAR_DOWN: gear_next = 1'b0;
                default:                 has_write = 1'b0;
            endcase
            cmd_next.ch_a        = jerc_pkg::CH_GEAR_FLAP;
            cmd_next.fixed_value = jerc_pkg::gear_flap_value(gear_next, flap_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_reg     <= 1'b0;
            flap_reg     <= jerc_pkg::FLAP_POS0;
            rfs_reg      <= 1'b0;
            stored_reg   <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept && has_write;
            if (accept)
            begin
                gear_reg   <= gear_next;
                flap_reg   <= flap_next;
                rfs_reg    <= rfs_next;
                stored_reg <= stored_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_cmd_reg <= cmd_next;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_cmd   = s1_cmd_reg;

endmodule

`default_nettype wire

>>> rtl/jerc_scale.sv
// ----------------------------------------------------------------------------
// jerc_scale
// Axis scaling (multiply, then divide by 32767), deadzone flags, ready latch.
// ----------------------------------------------------------------------------
`default_nettype none

module jerc_scale (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s1_valid,
    input  wire jerc_pkg::cmd_t  s1_cmd,
    output logic                 s2_valid,
    output logic                 q_push,
    output jerc_pkg::entry_t     q_wdata
);

    logic                s2_valid_reg;
    jerc_pkg::cmd_t      s2_cmd_reg;
    logic signed [26:0]  prod_reg;
    logic [3:0]          moved_reg, moved_next;
    logic                ready_reg, ready_next;

    logic                neg;
    logic [26:0]         mag_full;
    logic [9:0]          q0;
    logic [15:0]         rem;
    logic [9:0]          quot;
    logic [11:0]         sum;
    logic [10:0]         mapped;
    logic [10:0]         value;
    logic                outside;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            moved_reg    <= '0;
            ready_reg    <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid;
            moved_reg    <= moved_next;
            ready_reg    <= ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid)
        begin
            s2_cmd_reg <= s1_cmd;
            prod_reg   <= $signed({{10{s1_cmd.operand[16]}}, s1_cmd.operand})
                        * $signed({17'd0, jerc_pkg::SPAN});
        end
    end

    // |p| / 32767: q0 = |p| >> 15, remainder = low bits + q0, one correction
    always_comb
    begin
        neg      = prod_reg[26];
        mag_full = neg ? 27'(-prod_reg) : 27'(prod_reg);
        q0       = mag_full[24:15];
        rem      = {1'b0, mag_full[14:0]} + {6'd0, q0};
        quot     = q0 + {9'd0, rem >= jerc_pkg::FULL};
        sum      = neg ? jerc_pkg::CENTER - {2'd0, quot} : jerc_pkg::CENTER + {2'd0, quot};
        if (sum < jerc_pkg::VAL_MIN)
            mapped = jerc_pkg::VAL_MIN[10:0];
        else if (sum > jerc_pkg::VAL_MAX)
            mapped = jerc_pkg::VAL_MAX[10:0];
        else
            mapped = sum[10:0];
        value   = s2_cmd_reg.use_map ? mapped : s2_cmd_reg.fixed_value;
        outside = (value < jerc_pkg::DZ_LO) || (value > jerc_pkg::DZ_HI);
        moved_next = moved_reg;
        if (s2_valid_reg && outside)
            moved_next = moved_reg | s2_cmd_reg.mask;
        ready_next = ready_reg || (&moved_next);
    end

    assign s2_valid      = s2_valid_reg;
    assign q_push        = s2_valid_reg;
    assign q_wdata.ch_a  = s2_cmd_reg.ch_a;
    assign q_wdata.ch_b  = s2_cmd_reg.ch_b;
    assign q_wdata.two   = s2_cmd_reg.two;
    assign q_wdata.value = value;
    assign q_wdata.ready = ready_next;

endmodule

`default_nettype wire

>>> rtl/jerc_queue.sv
// ----------------------------------------------------------------------------
// jerc_queue
// Short FIFO of finished events between the scaling stages and the issue side.
// ----------------------------------------------------------------------------
`default_nettype none

module jerc_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire jerc_pkg::entry_t               wr_data,
    input  wire logic                           rd_en,
    output jerc_pkg::entry_t                    rd_data,
    output logic                                rd_valid,
    output logic [jerc_pkg::QUEUE_CW-1:0]       count
);

    jerc_pkg::entry_t                   mem [jerc_pkg::QUEUE_DEPTH];
    logic [jerc_pkg::QUEUE_AW-1:0]      wr_ptr_reg;
    logic [jerc_pkg::QUEUE_AW-1:0]      rd_ptr_reg;
    logic [jerc_pkg::QUEUE_CW-1:0]      count_reg;
    logic                               do_rd;

    assign do_rd = rd_en && (count_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({wr_en, do_rd})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    assign rd_data  = mem[rd_ptr_reg];
    assign rd_valid = count_reg != '0;
    assign count    = count_reg;

endmodule

`default_nettype wire

>>> rtl/jerc_back.sv
// ----------------------------------------------------------------------------
// jerc_back
// Output register: issues one or two channel writes per queued event.
// ----------------------------------------------------------------------------
`default_nettype none

module jerc_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  wire jerc_pkg::entry_t          q_data,
    output logic                           q_pop,
    output logic                           empty,
    input  wire logic                      pop,
    output jerc_pkg::channel_write_t       channel_write
);

    logic              out_valid_reg;
    logic              phase_reg;
    jerc_pkg::entry_t  hold_reg;
    logic              last;
    logic              advance;

    assign last    = !hold_reg.two || phase_reg;
    assign advance = !out_valid_reg || (pop && last);
    assign q_pop   = advance && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            phase_reg     <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= q_valid;
            phase_reg     <= 1'b0;
        end
        else if (pop)
        begin
            phase_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            hold_reg <= q_data;
    end

    assign empty                       = !out_valid_reg;
    assign channel_write.channel_index = phase_reg ? hold_reg.ch_b : hold_reg.ch_a;
    assign channel_write.channel_value = hold_reg.value;
    assign channel_write.ready_res     = hold_reg.ready;
    assign channel_write.last_write    = last;

endmodule

`default_nettype wire

>>> rtl/joystick_event_to_rc_channels_core.sv
// ----------------------------------------------------------------------------
// joystick_event_to_rc_channels_core
// Maps stick and pedal events to RC channel writes with flap/gear and rudder
// mode handling.
//
//   channel   signals               dir   payload
//   event     push / full           in    event_item  (event_item_t)
//   result    pop / empty           out   channel_write (channel_write_t)
//
// One event accepted per cycle unless full; it passes the classify register,
// the multiply register (then divide-by-32767 and flags) and the event queue
// to the output register, which issues one write per cycle unless pop is low,
// so a two-write event holds the result side until both are popped. full
// rises when the four-entry event queue plus the classify and scaling stages
// hold four events. Reset clears mode state, flags and all valid bits at once.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module joystick_event_to_rc_channels_core (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire jerc_pkg::event_item_t     event_item,
    output logic                           empty,
    input  wire logic                      pop,
    output jerc_pkg::channel_write_t       channel_write
);

    logic                                s1_valid;
    jerc_pkg::cmd_t                      s1_cmd;
    logic                                s2_valid;
    logic                                q_push;
    jerc_pkg::entry_t                    q_wdata;
    logic                                q_pop;
    jerc_pkg::entry_t                    q_rdata;
    logic                                q_valid;
    logic [jerc_pkg::QUEUE_CW-1:0]       q_count;

    jerc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .event_item (event_item),
        .s2_valid   (s2_valid),
        .q_count    (q_count),
        .s1_valid   (s1_valid),
        .s1_cmd     (s1_cmd)
    );

    jerc_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .s1_valid (s1_valid),
        .s1_cmd   (s1_cmd),
        .s2_valid (s2_valid),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    jerc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_data  (q_wdata),
        .rd_en    (q_pop),
        .rd_data  (q_rdata),
        .rd_valid (q_valid),
        .count    (q_count)
    );

    jerc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .empty         (empty),
        .pop           (pop),
        .channel_write (channel_write)
    );

    `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, q_push, q_count != 3'(jerc_pkg::QUEUE_DEPTH) || q_pop)
    `ASSERT_ALWAYS(a_credit_bound, clk, rst_n, (4'(q_count) + {3'd0, s1_valid} + {3'd0, s2_valid}) <= 4'(jerc_pkg::QUEUE_DEPTH))
    `ASSERT_IMPLIES(a_value_range, clk, rst_n, !empty, channel_write.channel_value >= 11'd172 && channel_write.channel_value <= 11'd1811)
    `ASSERT_IMPLIES(a_two_write_order, clk, rst_n, !empty && !channel_write.last_write, channel_write.channel_index == jerc_pkg::CH_AXIS_FIVE)

endmodule

`default_nettype wire

>>> sim/rc_write_checker.sv
// ----------------------------------------------------------------------------
// rc_write_checker
// Watches the event and channel-write queues of the stick/pedal to RC mapper,
// keeps its own copy of mode state and movement flags, predicts the writes
// of every accepted event and compares each popped write field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module rc_write_checker (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     push,
    input  wire logic                     full,
    input  wire jerc_pkg::event_item_t    event_item,
    input  wire logic                     empty,
    input  wire logic                     pop,
    input  wire jerc_pkg::channel_write_t channel_write,
    output int                            fail_count,
    output int                            writes_waiting,
    output int                            events_taken,
    output int                            writes_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MID_VALUE  = 992;
    localparam int SPAN_STEPS = 819;
    localparam int FULL_SCALE = 32767;
    localparam int LOW_LIMIT  = 172;
    localparam int HIGH_LIMIT = 1811;
    localparam int DEADBAND   = 50;

    logic [10:0] flap_gear_lut [2][4] = '{
        '{11'd172, 11'd499, 11'd826, 11'd172},
        '{11'd1153, 11'd1480, 11'd1811, 11'd172}
    };

    logic        gear_up;
    logic [1:0]  flap_sel;
    logic        stick_rudder_mode;
    logic [15:0] held_rudder_pos;
    logic [3:0]  moved;
    logic        ready_seen;

    jerc_pkg::channel_write_t pending_writes [$];
    jerc_pkg::channel_write_t want;

    initial
    begin
        fail_count     = 0;
        writes_waiting = 0;
        events_taken   = 0;
        writes_checked = 0;
    end

    function automatic logic [10:0] scale_position(input int pos);
        int s;
        s = MID_VALUE + (pos * SPAN_STEPS) / FULL_SCALE;
        if (s < LOW_LIMIT)
            s = LOW_LIMIT;
        if (s > HIGH_LIMIT)
            s = HIGH_LIMIT;
        return s[10:0];
    endfunction

    function automatic bit off_center(input logic [10:0] s);
        return (s < MID_VALUE - DEADBAND) || (s > MID_VALUE + DEADBAND);
    endfunction

    function automatic void map_event(input jerc_pkg::event_item_t ev);
        logic [3:0]               idx [2];
        logic [10:0]              val [2];
        int                       n;
        int                       pos;
        int                       k;
        bit                       hit;
        logic [3:0]               ch;
        logic [10:0]              s;
        jerc_pkg::channel_write_t w;
        n   = 0;
        pos = int'($signed(ev.event_value));
        if (ev.from_pedals)
        begin
            if (!ev.is_button && ev.control_number == jerc_pkg::AXIS_PEDAL_RUDDER
                && !stick_rudder_mode)
            begin
                s = scale_position(pos);
                idx[n] = jerc_pkg::CH_RUDDER;
                val[n] = s;
                n++;
                if (off_center(s))
                    moved[3] = 1'b1;
            end
        end
        else if (!ev.is_button)
        begin
            if (ev.control_number < jerc_pkg::AXIS_SHIFT_END)
            begin
                ch = (ev.control_number >= jerc_pkg::AXIS_FIRST_SHIFT) ?
                     ev.control_number[3:0] + jerc_pkg::CH_SHIFT : ev.control_number[3:0];
                s = (ch == jerc_pkg::CH_INVERTED) ? scale_position(-pos)
                                                  : scale_position(pos);
                idx[n] = ch;
                val[n] = s;
                n++;
                if (ch < jerc_pkg::CH_RUDDER && off_center(s))
                    moved[ch] = 1'b1;
                if (ch == jerc_pkg::CH_AXIS_FIVE)
                begin
                    held_rudder_pos = ev.event_value;
                    if (stick_rudder_mode)
                    begin
                        s = scale_position(pos);
                        idx[n] = jerc_pkg::CH_RUDDER;
                        val[n] = s;
                        n++;
                        if (off_center(s))
                            moved[3] = 1'b1;
                    end
                end
            end
            else if (ev.control_number < jerc_pkg::AXIS_END)
            begin
                idx[n] = ev.control_number[3:0];
                val[n] = scale_position(pos);
                n++;
            end
        end
        else if (ev.control_number == jerc_pkg::BTN_TOGGLE && pos != 1)
        begin
            // toggle acts on release; moved flag 3 untouched
            stick_rudder_mode = ~stick_rudder_mode;
            if (stick_rudder_mode)
            begin
                idx[n] = jerc_pkg::CH_RUDDER;
                val[n] = scale_position(int'($signed(held_rudder_pos)));
                n++;
            end
        end
        else if (pos == 1)
        begin
            hit = 1'b1;
            case (ev.control_number)
                jerc_pkg::BTN_FLAP_POS0: flap_sel = jerc_pkg::FLAP_POS0;
                jerc_pkg::BTN_FLAP_POS1: flap_sel = jerc_pkg::FLAP_POS1;
                jerc_pkg::BTN_FLAP_POS2: flap_sel = jerc_pkg::FLAP_POS2;
                jerc_pkg::BTN_GEAR_UP:   gear_up = 1'b1;
                jerc_pkg::BTN_GEAR_DOWN: gear_up = 1'b0;
                default:                 hit = 1'b0;
            endcase
            if (hit)
            begin
                idx[n] = jerc_pkg::CH_GEAR_FLAP;
                val[n] = flap_gear_lut[gear_up][flap_sel];
                n++;
            end
        end
        if (&moved)
            ready_seen = 1'b1;
        for (k = 0; k < n; k++)
        begin
            w.channel_index = idx[k];
            w.channel_value = val[k];
            w.ready_res     = ready_seen;
            w.last_write    = (k == n - 1);
            pending_writes.push_back(w);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gear_up           = 1'b0;
            flap_sel          = jerc_pkg::FLAP_POS0;
            stick_rudder_mode = 1'b0;
            held_rudder_pos   = '0;
            moved             = '0;
            ready_seen        = 1'b0;
            pending_writes.delete();
            writes_waiting <= 0;
        end
        else
        begin
            if (push && !full)
            begin
                events_taken++;
                map_event(event_item);
            end
            if (pop && !empty)
            begin
                writes_checked++;
                if (pending_writes.size() == 0)
                begin
                    $error("unexpected channel write: index %0d value %0d",
                           channel_write.channel_index, channel_write.channel_value);
                    fail_count++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (channel_write.channel_index !== want.channel_index)
                    begin
                        $error("channel_index: expected %0d, got %0d",
                               want.channel_index, channel_write.channel_index);
                        fail_count++;
                    end
                    if (channel_write.channel_value !== want.channel_value)
                    begin
                        $error("channel_value: expected %0d, got %0d",
                               want.channel_value, channel_write.channel_value);
                        fail_count++;
                    end
                    if (channel_write.ready_res !== want.ready_res)
                    begin
                        $error("ready_res: expected %0b, got %0b",
                               want.ready_res, channel_write.ready_res);
                        fail_count++;
                    end
                    if (channel_write.last_write !== want.last_write)
                    begin
                        $error("last_write: expected %0b, got %0b",
                               want.last_write, channel_write.last_write);
                        fail_count++;
                    end
                end
            end
            writes_waiting <= pending_writes.size();
        end
    end

endmodule

`default_nettype wire

>>> sim/joystick_event_to_rc_channels_core_test.sv
// ----------------------------------------------------------------------------
// joystick_event_to_rc_channels_core_test
// Drives stick and pedal events into the mapper: a directed pass over every
// axis range, the rudder toggle, flap and gear buttons and ignored events,
// then random events with random push gaps and pop stalls. Checking is done
// by rc_write_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module joystick_event_to_rc_channels_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_EVENTS  = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    logic                     clk;
    logic                     rst_n;
    logic                     push;
    logic                     full;
    jerc_pkg::event_item_t    event_item;
    logic                     empty;
    logic                     pop = 1'b0;
    jerc_pkg::channel_write_t channel_write;

    int fail_count;
    int writes_waiting;
    int events_taken;
    int writes_checked;
    int idle_cycles = 0;
    int pop_stall = 0;
    int stall_draw;
    bit pop_steady = 1'b0;
    bit push_steady = 1'b0;

    joystick_event_to_rc_channels_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .event_item    (event_item),
        .empty         (empty),
        .pop           (pop),
        .channel_write (channel_write)
    );

    rc_write_checker write_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .event_item     (event_item),
        .empty          (empty),
        .pop            (pop),
        .channel_write  (channel_write),
        .fail_count     (fail_count),
        .writes_waiting (writes_waiting),
        .events_taken   (events_taken),
        .writes_checked (writes_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            pop       <= 1'b0;
            pop_stall <= 0;
        end
        else if (pop && !empty)
        begin
            if ($urandom_range(0, 63) == 0)
                pop_steady <= ~pop_steady;
            stall_draw = pop_steady ? 0 : $urandom_range(0, 6);
            pop_stall <= stall_draw;
            pop       <= (stall_draw == 0);
        end
        else if (pop_stall != 0)
        begin
            pop_stall <= pop_stall - 1;
            pop       <= (pop_stall == 1);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_event_item(input jerc_pkg::event_item_t ev);
        int gap;
        gap = push_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push       <= 1'b1;
        event_item <= ev;
        do
            @(posedge clk);
        while (full);
    endtask

    task automatic send_fields(input bit ped, input bit btn, input logic [7:0] num,
                               input int val);
        jerc_pkg::event_item_t ev;
        ev.from_pedals    = ped;
        ev.is_button      = btn;
        ev.control_number = num;
        ev.event_value    = 16'(val);
        send_event_item(ev);
    endtask

    function automatic logic [15:0] draw_position();
        int mag;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            case ($urandom_range(0, 5))
                0:       return 16'h8000;
                1:       return 16'h7fff;
                2:       return 16'h8001;
                3:       return 16'h0000;
                4:       return 16'h0001;
                default: return 16'hffff;
            endcase
        end
        else if (pick < 40)
        begin
            // around the deadzone edges
            mag = $urandom_range(1850, 2150);
            return $urandom_range(0, 1) ? 16'(mag) : 16'(-mag);
        end
        return 16'($urandom);
    endfunction

    function automatic logic [15:0] draw_button_value();
        if ($urandom_range(0, 9) < 7)
            return 16'd1;
        return $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
    endfunction

    function automatic jerc_pkg::event_item_t draw_event();
        jerc_pkg::event_item_t ev;
        int                    pick;
        pick = $urandom_range(0, 99);
        ev.from_pedals = 1'b0;
        ev.is_button   = 1'b0;
        if (pick < 40)
        begin
            ev.control_number = ($urandom_range(0, 3) == 0) ?
                                jerc_pkg::AXIS_STICK_RUDDER : 8'($urandom_range(0, 15));
            ev.event_value = draw_position();
        end
        else if (pick < 52)
        begin
            ev.from_pedals    = 1'b1;
            ev.control_number = jerc_pkg::AXIS_PEDAL_RUDDER;
            ev.event_value    = draw_position();
        end
        else if (pick < 62)
        begin
            ev.is_button      = 1'b1;
            ev.control_number = jerc_pkg::BTN_TOGGLE;
            ev.event_value    = draw_button_value();
        end
        else if (pick < 80)
        begin
            ev.is_button      = 1'b1;
            ev.control_number = 8'($urandom_range(jerc_pkg::BTN_FLAP_POS0,
                                                  jerc_pkg::BTN_GEAR_DOWN));
            ev.event_value    = draw_button_value();
        end
        else
        begin
            ev.from_pedals    = 1'($urandom);
            ev.is_button      = 1'($urandom);
            ev.control_number = 8'($urandom);
            ev.event_value    = $urandom_range(0, 1) ? draw_button_value() : 16'($urandom);
        end
        return ev;
    endfunction

    initial
    begin
        int k;
        rst_n      = 1'b0;
        push       = 1'b0;
        event_item = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(1'b0, 1'b0, 8'd0, 32767);
        send_fields(1'b0, 1'b0, 8'd1, -32768);
        send_fields(1'b0, 1'b0, 8'd2, -32768);
        send_fields(1'b0, 1'b0, jerc_pkg::AXIS_STICK_RUDDER, -12345);
        send_fields(1'b1, 1'b0, jerc_pkg::AXIS_PEDAL_RUDDER, 20000);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_TOGGLE, 1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_TOGGLE, 0);
        send_fields(1'b0, 1'b0, jerc_pkg::AXIS_STICK_RUDDER, 32767);
        send_fields(1'b1, 1'b0, jerc_pkg::AXIS_PEDAL_RUDDER, 0);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_TOGGLE, -1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_FLAP_POS1, 1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_GEAR_UP, 1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_FLAP_POS2, 1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_FLAP_POS0, 1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_GEAR_DOWN, 1);
        send_fields(1'b0, 1'b1, jerc_pkg::BTN_GEAR_DOWN, 0);
        send_fields(1'b0, 1'b0, 8'd3, 0);
        send_fields(1'b0, 1'b0, 8'd7, 1);
        send_fields(1'b0, 1'b0, 8'd8, -1);
        send_fields(1'b0, 1'b0, 8'd15, 2000);
        send_fields(1'b0, 1'b0, 8'd16, 100);
        send_fields(1'b0, 1'b0, 8'd255, -32768);
        send_fields(1'b1, 1'b1, jerc_pkg::AXIS_PEDAL_RUDDER, 1);
        send_fields(1'b1, 1'b0, 8'd7, 5);
        send_fields(1'b0, 1'b1, 8'd200, 1);

        for (k = 0; k < RANDOM_EVENTS; k++)
        begin
            if (k % 100 == 0)
                push_steady = ($urandom_range(0, 3) == 0);
            send_event_item(draw_event());
        end
        push <= 1'b0;

        @(posedge clk);
        while (writes_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d events and %0d channel writes: all axis ranges, rudder toggle,",
                 events_taken, writes_checked);
        $display("flap/gear presses and ignored events, under random push gaps and pop stalls");
        if (fail_count == 0 && writes_waiting == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
